@@ hdl/pba_pkg.sv @@
// Shared types and constants for the page bitmap allocator.
package pba_pkg;

    localparam int WORD_BITS = 32;
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int OFS_W     = 32;
    localparam int POFS_W    = 22;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_PAGE = 2'd1;
    localparam logic [1:0] ST_BAD     = 2'd2;

    typedef struct packed {
        logic             action;
        logic [OFS_W-1:0] byte_offset;
    } t_in_item;

    typedef struct packed {
        logic [1:0]        status;
        logic [POFS_W-1:0] page_offset;
    } t_out_item;

endpackage

@@ hdl/pba_find_first.sv @@
// Lowest set bit of one bitmap word.
module pba_find_first
    import pba_pkg::*;
(
    input  logic [WORD_BITS-1:0] i_vec,
    output logic [BIT_W-1:0]     o_idx
);

    always_comb begin
        o_idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (i_vec[i]) begin
                o_idx = BIT_W'(i);
            end
        end
    end

endmodule

@@ hdl/page_bitmap_allocator_top.sv @@
// Page bitmap allocator: first-fit page allocator over a word-wide bitmap memory.
//
// Input channel (i_in_valid / o_in_stall / i_in_item): one request per item,
// allocate (lowest free page) or free (by byte offset). Output channel
// (o_out_valid / i_out_stall / o_out_item): exactly one result per request.
// An item is taken when valid is high and stall is low.
//
// The bitmap sits in a memory of ceil(PAGE_COUNT/32) words; a flip-flop per
// word marks it full, and that summary is searched 32 words per cycle.
// Steps after a request is taken: an allocate searches the summary, then
// reads the chosen word, writes it back and loads the result; with no free
// page it loads the result right after the search. A free does a reciprocal
// multiply by 1/PAGE_BYTES, an alignment check, read, write-back and result
// load; a misaligned free skips read and write-back, and an out-of-pool free
// goes straight to result load. One request is in flight at a time; the next
// is taken the cycle after the result is loaded into the output register,
// even while the receiver stalls it.
//
// After reset the block runs a clearing pass of one word per cycle with
// o_in_stall high. A stalled result holds in the output register until
// taken.
module page_bitmap_allocator_top
    import pba_pkg::*;
#(
    parameter int PAGE_COUNT = 1024,
    parameter int PAGE_BYTES = 4096
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    localparam int WORD_COUNT  = (PAGE_COUNT + WORD_BITS - 1) / WORD_BITS;
    localparam int WIDX_W      = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int PAGE_W      = WIDX_W + BIT_W;
    localparam int CHUNK_COUNT = (WORD_COUNT + WORD_BITS - 1) / WORD_BITS;
    localparam int CIDX_W      = (CHUNK_COUNT > 1) ? $clog2(CHUNK_COUNT) : 1;
    localparam int PB_W        = $clog2(PAGE_BYTES + 1);
    localparam int PROD_W      = PAGE_W + PB_W;
    localparam int CMP_W       = (PROD_W > OFS_W) ? PROD_W : OFS_W;
    localparam int TAIL        = PAGE_COUNT - (WORD_COUNT - 1) * WORD_BITS;
    localparam int RCP_SH      = OFS_W + $clog2(PAGE_BYTES);
    localparam int LO_W        = 16;
    localparam int PLO_W       = OFS_W + LO_W;
    localparam int PHI_W       = OFS_W + OFS_W - LO_W + 1;
    localparam int SUM_W       = PHI_W + LO_W;

    localparam logic [OFS_W:0]        POOL_BYTES = (OFS_W+1)'(PAGE_COUNT) *
                                                   (OFS_W+1)'(PAGE_BYTES);
    // ceil(2^RCP_SH / PAGE_BYTES): exact quotient for any 32-bit offset
    localparam logic [OFS_W:0]        RCP        = (OFS_W+1)'(
        ((64'd1 << RCP_SH) + 64'(PAGE_BYTES) - 64'd1) / 64'(PAGE_BYTES));
    localparam logic [LO_W-1:0]       RCP_LO     = RCP[LO_W-1:0];
    localparam logic [OFS_W-LO_W:0]   RCP_HI     = RCP[OFS_W:LO_W];
    localparam logic [WORD_BITS-1:0]  LAST_INIT  =
        WORD_BITS'(~((64'd1 << TAIL) - 64'd1));
    localparam logic [WIDX_W-1:0]     LAST_WORD  = WIDX_W'(WORD_COUNT - 1);
    localparam logic [CIDX_W-1:0]     LAST_CHUNK = CIDX_W'(CHUNK_COUNT - 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_FCHK  = 3'd4;
    localparam logic [2:0] S_RD    = 3'd5;
    localparam logic [2:0] S_WR    = 3'd6;
    localparam logic [2:0] S_FIN   = 3'd7;

    logic [2:0]            r_state, n_state;
    logic [WIDX_W-1:0]     r_clr;
    logic [CIDX_W-1:0]     r_chunk;
    logic [OFS_W-1:0]      r_ofs;
    logic [PLO_W-1:0]      r_plo;
    logic [PHI_W-1:0]      r_phi;
    logic [PAGE_W-1:0]     r_page;
    logic                  r_is_free;
    logic [1:0]            r_status;
    logic [WORD_COUNT-1:0] r_full;
    logic [WORD_BITS-1:0]  r_rd_data;
    logic                  r_out_valid;
    t_out_item             r_out_item;

    logic [WORD_BITS-1:0]  mem [WORD_COUNT];

    logic                         in_acc;
    logic                         out_free;
    logic [CHUNK_COUNT*WORD_BITS-1:0] full_pad;
    logic [WORD_BITS-1:0]         free_slice;
    logic                         chunk_hit;
    logic [BIT_W-1:0]             chunk_idx;
    logic [WIDX_W-1:0]            hit_word;
    logic [BIT_W-1:0]             bit_idx;
    logic [WIDX_W-1:0]            cur_word;
    logic [WORD_BITS-1:0]         set_word;
    logic [WORD_BITS-1:0]         clr_word;
    logic [SUM_W-1:0]             quo_sum;
    logic [PAGE_W-1:0]            quo_page;
    logic                         misaligned;
    logic                         out_of_pool;
    logic [PROD_W-1:0]            prod;
    logic                         mem_we;
    logic [WIDX_W-1:0]            mem_addr;
    logic [WORD_BITS-1:0]         mem_wdata;

    assign in_acc      = i_in_valid && (r_state == S_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    assign out_of_pool = {1'b0, i_in_item.byte_offset} >= POOL_BYTES;

    // summary of full words, padded with full entries past the last word
    always_comb begin
        full_pad               = '1;
        full_pad[WORD_COUNT-1:0] = r_full;
    end

    assign free_slice = ~full_pad[r_chunk*WORD_BITS +: WORD_BITS];
    assign chunk_hit  = |free_slice;

    pba_find_first u_chunk_ff (
        .i_vec (free_slice),
        .o_idx (chunk_idx)
    );

    pba_find_first u_bit_ff (
        .i_vec (~r_rd_data),
        .o_idx (bit_idx)
    );

    assign hit_word = WIDX_W'({r_chunk, chunk_idx});
    assign cur_word = r_page[PAGE_W-1:BIT_W];
    assign set_word = r_rd_data | (WORD_BITS'(1) << bit_idx);
    assign clr_word = r_rd_data & ~(WORD_BITS'(1) << r_page[BIT_W-1:0]);

    // page index from the two registered partial products
    assign quo_sum  = {r_phi, {LO_W{1'b0}}} + SUM_W'(r_plo);
    assign quo_page = PAGE_W'(quo_sum >> RCP_SH);

    assign prod       = PROD_W'(r_page) * PROD_W'(PAGE_BYTES);
    assign misaligned = CMP_W'(prod) != CMP_W'(r_ofs);

    assign mem_we    = (r_state == S_CLEAR) || (r_state == S_WR);
    assign mem_addr  = (r_state == S_CLEAR) ? r_clr : cur_word;

    always_comb begin
        if (r_state == S_CLEAR) begin
            mem_wdata = (r_clr == LAST_WORD) ? LAST_INIT : '0;
        end else if (r_is_free) begin
            mem_wdata = clr_word;
        end else begin
            mem_wdata = set_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        r_rd_data <= mem[cur_word];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_clr == LAST_WORD) n_state = S_IDLE;
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in_item.action == ACT_ALLOC) begin
                        n_state = S_SCAN;
                    end else if (out_of_pool) begin
                        n_state = S_FIN;
                    end else begin
                        n_state = S_DIV;
                    end
                end
            end
            S_SCAN: begin
                if (chunk_hit) begin
                    n_state = S_RD;
                end else if (r_chunk == LAST_CHUNK) begin
                    n_state = S_FIN;
                end
            end
            S_DIV:  n_state = S_FCHK;
            S_FCHK: n_state = misaligned ? S_FIN : S_RD;
            S_RD:   n_state = S_WR;
            S_WR:   n_state = S_FIN;
            S_FIN:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_full      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_FIN && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: r_clr <= r_clr + 1'b1;
                S_IDLE: begin
                    if (in_acc) begin
                        r_is_free <= (i_in_item.action == ACT_FREE);
                        r_chunk   <= '0;
                        r_ofs     <= i_in_item.byte_offset;
                        r_plo     <= PLO_W'(i_in_item.byte_offset) * PLO_W'(RCP_LO);
                        r_phi     <= PHI_W'(i_in_item.byte_offset) * PHI_W'(RCP_HI);
                        r_page    <= '0;
                        r_status  <= (i_in_item.action == ACT_FREE && out_of_pool)
                                     ? ST_BAD : ST_OK;
                    end
                end
                S_SCAN: begin
                    if (chunk_hit) begin
                        r_page <= {hit_word, BIT_W'(0)};
                    end else if (r_chunk == LAST_CHUNK) begin
                        r_status <= ST_NO_PAGE;
                    end else begin
                        r_chunk <= r_chunk + 1'b1;
                    end
                end
                S_DIV:  r_page <= quo_page;
                S_FCHK: if (misaligned) r_status <= ST_BAD;
                S_RD: ;
                S_WR: begin
                    if (r_is_free) begin
                        r_full[cur_word] <= 1'b0;
                    end else begin
                        r_page[BIT_W-1:0] <= bit_idx;
                        r_full[cur_word]  <= &set_word;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_out_item.status <= r_status;
                        r_out_item.page_offset <= (r_status == ST_OK && !r_is_free)
                                                  ? POFS_W'(prod) : '0;
                    end
                end
                default: ;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_alloc_scans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in_item.action == ACT_ALLOC |=> r_state == S_SCAN)
        else $error("allocate did not start the summary search");

    a_word_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WR && !r_is_free |-> !(&r_rd_data))
        else $error("word picked for allocation has no free page");

    a_free_in_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FCHK |-> {1'b0, r_page} < (PAGE_W+1)'(PAGE_COUNT))
        else $error("divided page index lies outside the pool");

    a_fail_no_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status != ST_OK |-> o_out_item.page_offset == '0)
        else $error("failed request carries a page offset");

    a_leave_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_state != S_IDLE)
        else $error("item taken but block stayed idle");
`endif

endmodule

@@ dv/tb.sv @@
// Testbench for the page bitmap allocator: directed table, pool fill, random requests.
`timescale 1ns / 100ps

module tb;
    import pba_pkg::*;

    localparam int PAGE_COUNT  = 1024;
    localparam int PAGE_BYTES  = 4096;
    localparam int QUIET_LIMIT = 5000;
    localparam int HOLD_CYCLES = 200;
    localparam int PHASE_ITEMS = 30;

    typedef struct packed {
        t_in_item  req;
        logic      typed;
        t_out_item want;
    } t_plan_row;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_item;

    // predictor state
    bit        page_busy [PAGE_COUNT];
    int        pages_taken = 0;

    t_out_item pending_results [$];
    t_plan_row plan_opening [$];
    t_plan_row plan_full [$];

    int        errors = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    logic      hold_tgl = 1'b0;
    logic      hold_seen = 1'b0;
    int        hold_left = 0;
    int        quiet_cycles = 0;
    t_out_item want_now;

    page_bitmap_allocator_top #(
        .PAGE_COUNT(PAGE_COUNT),
        .PAGE_BYTES(PAGE_BYTES)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_item (out_item)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Works out the result of one request and updates the bitmap copy.
    function automatic t_out_item allocator_result(t_in_item req);
        t_out_item         res;
        longint            page;
        longint unsigned   ofs;
        res.status      = ST_OK;
        res.page_offset = '0;
        if (req.action == ACT_ALLOC) begin
            page = -1;
            for (int i = 0; i < PAGE_COUNT; i++) begin
                if (!page_busy[i]) begin
                    page = i;
                    break;
                end
            end
            if (page < 0) begin
                res.status = ST_NO_PAGE;
            end else begin
                page_busy[page] = 1'b1;
                pages_taken++;
                res.page_offset = POFS_W'(page * PAGE_BYTES);
            end
        end else begin
            ofs = req.byte_offset;
            if (ofs % PAGE_BYTES == 0 && ofs / PAGE_BYTES < PAGE_COUNT) begin
                page = ofs / PAGE_BYTES;
                if (page_busy[page])
                    pages_taken--;
                page_busy[page] = 1'b0;
            end else begin
                res.status = ST_BAD;
            end
        end
        return res;
    endfunction

    function automatic t_plan_row plan_row(logic act, logic [OFS_W-1:0] ofs, logic typed,
                                           logic [1:0] st, logic [POFS_W-1:0] pofs);
        t_plan_row row;
        row.req.action       = act;
        row.req.byte_offset  = ofs;
        row.typed            = typed;
        row.want.status      = st;
        row.want.page_offset = pofs;
        return row;
    endfunction

    function automatic t_in_item random_request(int alloc_pct);
        t_in_item req;
        int       r;
        r = $urandom_range(99);
        req.byte_offset = $urandom;
        if (r < alloc_pct) begin
            req.action = ACT_ALLOC;
        end else begin
            req.action = ACT_FREE;
            if (r < 88)
                req.byte_offset = $urandom_range(PAGE_COUNT - 1) * PAGE_BYTES;
            else if (r < 94)
                req.byte_offset = $urandom_range(PAGE_COUNT - 1) * PAGE_BYTES
                                  + $urandom_range(PAGE_BYTES - 1, 1);
            else if (r < 97)
                req.byte_offset = $urandom_range(32'h000F_FFFF, PAGE_COUNT) * PAGE_BYTES;
        end
        return req;
    endfunction

    task automatic send_item(t_in_item req, logic typed, t_out_item want);
        int        gap;
        t_out_item got;
        gap = 0;
        while (gap < 60 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= req;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        got = allocator_result(req);
        pending_results.push_back(typed ? want : got);
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // result side: random stall, long hold on request, checking
    always @(posedge clk) begin
        if (rst_n) begin
            if (hold_tgl != hold_seen) begin
                hold_seen = hold_tgl;
                hold_left = HOLD_CYCLES;
            end
            if (out_valid && !out_stall) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected item status %0d page_offset %h",
                             $time, out_item.status, out_item.page_offset);
                    errors++;
                end else begin
                    want_now = pending_results.pop_front();
                    if (out_item.status !== want_now.status) begin
                        $display("%0t: status expected %0d got %0d",
                                 $time, want_now.status, out_item.status);
                        errors++;
                    end
                    if (out_item.page_offset !== want_now.page_offset) begin
                        $display("%0t: page_offset expected %h got %h",
                                 $time, want_now.page_offset, out_item.page_offset);
                        errors++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: timeout, no item moved for %0d cycles", $time, quiet_cycles);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        int idle_set  [4];
        int stall_set [4];
        int alloc_set [4];
        idle_set  = '{0, 86, 0, 29};
        stall_set = '{0, 0, 86, 29};
        alloc_set = '{50, 25, 60, 40};

        // opening rows: first allocations, refree, bad addresses, extremes
        plan_opening.push_back(plan_row(ACT_ALLOC, 32'h0000_0000, 1'b1, ST_OK, 22'h00_0000));
        plan_opening.push_back(plan_row(ACT_ALLOC, 32'h0000_0000, 1'b1, ST_OK, 22'h00_1000));
        plan_opening.push_back(plan_row(ACT_ALLOC, 32'h0000_0000, 1'b1, ST_OK, 22'h00_2000));
        plan_opening.push_back(plan_row(ACT_FREE,  32'h0000_1000, 1'b1, ST_OK, 22'h00_0000));
        plan_opening.push_back(plan_row(ACT_FREE,  32'h0000_1000, 1'b1, ST_OK, 22'h00_0000));
        plan_opening.push_back(plan_row(ACT_ALLOC, 32'h0000_0000, 1'b1, ST_OK, 22'h00_1000));
        plan_opening.push_back(plan_row(ACT_FREE,  32'h0000_0001, 1'b1, ST_BAD, 22'h00_0000));
        plan_opening.push_back(plan_row(ACT_FREE,  32'h0000_0FFF, 1'b1, ST_BAD, 22'h00_0000));
        plan_opening.push_back(plan_row(ACT_FREE,  32'h0040_0000, 1'b1, ST_BAD, 22'h00_0000));
        plan_opening.push_back(plan_row(ACT_FREE,  32'hFFFF_FFFF, 1'b1, ST_BAD, 22'h00_0000));
        plan_opening.push_back(plan_row(ACT_FREE,  32'hFFFF_F000, 1'b1, ST_BAD, 22'h00_0000));
        plan_opening.push_back(plan_row(ACT_FREE,  32'h003F_F000, 1'b1, ST_OK, 22'h00_0000));
        plan_opening.push_back(plan_row(ACT_FREE,  32'h0000_0800, 1'b1, ST_BAD, 22'h00_0000));
        plan_opening.push_back(plan_row(ACT_ALLOC, 32'hFFFF_FFFF, 1'b1, ST_OK, 22'h00_3000));
        plan_opening.push_back(plan_row(ACT_FREE,  32'h8000_0000, 1'b1, ST_BAD, 22'h00_0000));
        plan_opening.push_back(plan_row(ACT_FREE,  32'h0000_0000, 1'b1, ST_OK, 22'h00_0000));
        plan_opening.push_back(plan_row(ACT_ALLOC, 32'h0000_0000, 1'b1, ST_OK, 22'h00_0000));

        // rows run against a full pool
        plan_full.push_back(plan_row(ACT_ALLOC, 32'h0000_0000, 1'b1, ST_NO_PAGE, 22'h00_0000));
        plan_full.push_back(plan_row(ACT_ALLOC, 32'hFFFF_FFFF, 1'b1, ST_NO_PAGE, 22'h00_0000));
        plan_full.push_back(plan_row(ACT_FREE,  32'h003F_F000, 1'b1, ST_OK, 22'h00_0000));
        plan_full.push_back(plan_row(ACT_ALLOC, 32'h0000_0000, 1'b1, ST_OK, 22'h3F_F000));
        plan_full.push_back(plan_row(ACT_FREE,  32'h0020_0000, 1'b1, ST_OK, 22'h00_0000));
        plan_full.push_back(plan_row(ACT_FREE,  32'h0020_0001, 1'b1, ST_BAD, 22'h00_0000));
        plan_full.push_back(plan_row(ACT_ALLOC, 32'h0000_0000, 1'b1, ST_OK, 22'h20_0000));
        plan_full.push_back(plan_row(ACT_ALLOC, 32'h0000_0000, 1'b1, ST_NO_PAGE, 22'h00_0000));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan_opening[i])
            send_item(plan_opening[i].req, plan_opening[i].typed, plan_opening[i].want);

        // fill the pool with light idling on both sides
        send_idle_pct  = 29;
        recv_stall_pct <= 29;
        while (pages_taken < PAGE_COUNT)
            send_item(t_in_item'({ACT_ALLOC, 32'($urandom)}), 1'b0, '0);
        wait_for_results();

        send_idle_pct  = 0;
        recv_stall_pct <= 0;
        foreach (plan_full[i])
            send_item(plan_full[i].req, plan_full[i].typed, plan_full[i].want);
        wait_for_results();

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = idle_set[ph];
            recv_stall_pct <= stall_set[ph];
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // long hold-off on the result side while requests keep coming
                if (ph == 0 && n == 10)
                    hold_tgl <= ~hold_tgl;
                send_item(random_request(alloc_set[ph]), 1'b0, '0);
            end
            wait_for_results();
        end

        repeat (20) @(posedge clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ page_bitmap_allocator_top.f @@
hdl/pba_pkg.sv
hdl/pba_find_first.sv
hdl/page_bitmap_allocator_top.sv
dv/tb.sv
